>>> src/mip_level_box_downsampler_top_assert.svh
// assertion macros for the mip level box downsampler top level
// expects aclk and aresetn in the scope of each use
`ifndef MIP_LEVEL_BOX_DOWNSAMPLER_TOP_ASSERT_SVH
`define MIP_LEVEL_BOX_DOWNSAMPLER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MLBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MLBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mlbd_pkg.sv
// shared constants, types and helper functions of the mip level box downsampler
// no dependencies
package mlbd_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int PIX_W           = 32;
    localparam int LANE_W          = 9;
    localparam int SUM_W           = 4 * LANE_W;
    localparam int ROW_W           = 12;
    localparam int HEIGHT_LOG2_MAX = 12;
    localparam int LOG2_W          = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_TB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_LR   = 3'd4;

    // item handed from the line store stage to the averaging stage
    typedef struct packed {
        logic [SUM_W-1:0] hsum;
        logic             use_above;
        logic             alpha_zero;
        logic             level_end;
    } mlbd_stage_t;

    // floor(log2(max_width)): bits of the source column counter
    function automatic int col_bits(input int max_width);
        return $clog2(max_width + 1) - 1;
    endfunction

    // address bits of the line store, at least one
    function automatic int addr_bits(input int max_width);
        int c;
        c = col_bits(max_width);
        return (c > 1) ? c - 1 : 1;
    endfunction

    // four 9-bit channel sums of two pixels
    function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            r[c*LANE_W +: LANE_W] = {1'b0, a[c*8 +: 8]} + {1'b0, b[c*8 +: 8]};
        end
        return r;
    endfunction

endpackage

>>> src/mlbd_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module mlbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/mlbd_front.sv
// config registers, source position tracking, horizontal pairing and line store access
// depends on mlbd_pkg
module mlbd_front #(
    parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [mlbd_pkg::CFG_IDX_W-1:0]          cfg_wr_index,
    input  logic [mlbd_pkg::CFG_DATA_W-1:0]         cfg_wr_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [mlbd_pkg::PIX_W-1:0]              s_tdata,
    input  logic                                    s1_take,
    output logic                                    s1_valid,
    output mlbd_pkg::mlbd_stage_t                   s1,
    output logic                                    ram_wr_en,
    output logic [mlbd_pkg::addr_bits(MAX_WIDTH)-1:0] ram_wr_addr,
    output logic [mlbd_pkg::SUM_W-1:0]              ram_wr_data,
    output logic                                    ram_rd_en,
    output logic [mlbd_pkg::addr_bits(MAX_WIDTH)-1:0] ram_rd_addr
);

    localparam int COL_W  = mlbd_pkg::col_bits(MAX_WIDTH);
    localparam int ADDR_W = mlbd_pkg::addr_bits(MAX_WIDTH);
    localparam int ROW_W  = mlbd_pkg::ROW_W;

    logic [mlbd_pkg::LOG2_W-1:0] width_log2_reg, height_log2_reg;
    logic                        has_alpha_reg, border_tb_reg, border_lr_reg;
    logic [COL_W-1:0]            src_col_reg, src_col_next;
    logic [ROW_W-1:0]            src_row_reg, src_row_next;
    logic [mlbd_pkg::PIX_W-1:0]  pair_hold_reg;
    logic                        s1_valid_reg;
    mlbd_pkg::mlbd_stage_t       s1_reg, s1_next;

    logic                        cfg_hit, s_acc;
    logic [mlbd_pkg::LOG2_W-1:0] wl_eff, hl_eff;
    logic [COL_W-1:0]            wmask, col, col_half;
    logic [ROW_W-1:0]            rmask, row;
    logic                        w1, h1, last_col, last_row, first_col, first_row;
    logic                        pair_done, wr_need, rd_need, emit;
    logic [mlbd_pkg::SUM_W-1:0]  hsum;

    assign cfg_hit = cfg_wr_en && (cfg_wr_index inside
                     {[mlbd_pkg::REG_WIDTH_LOG2 : mlbd_pkg::REG_BORDER_LR]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_log2_reg  <= '0;
            height_log2_reg <= '0;
            has_alpha_reg   <= 1'b1;
            border_tb_reg   <= 1'b0;
            border_lr_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                mlbd_pkg::REG_WIDTH_LOG2:  width_log2_reg  <= cfg_wr_data;
                mlbd_pkg::REG_HEIGHT_LOG2: height_log2_reg <= cfg_wr_data;
                mlbd_pkg::REG_HAS_ALPHA:   has_alpha_reg   <= cfg_wr_data[0];
                mlbd_pkg::REG_BORDER_TB:   border_tb_reg   <= cfg_wr_data[0];
                mlbd_pkg::REG_BORDER_LR:   border_lr_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // clamp sizes and build position masks
    always_comb begin
        wl_eff = (width_log2_reg > mlbd_pkg::LOG2_W'(COL_W)) ?
                 mlbd_pkg::LOG2_W'(COL_W) : width_log2_reg;
        hl_eff = (height_log2_reg > mlbd_pkg::LOG2_W'(mlbd_pkg::HEIGHT_LOG2_MAX)) ?
                 mlbd_pkg::LOG2_W'(mlbd_pkg::HEIGHT_LOG2_MAX) : height_log2_reg;
        wmask     = ~({COL_W{1'b1}} << wl_eff);
        rmask     = ~({ROW_W{1'b1}} << hl_eff);
        col       = src_col_reg & wmask;
        row       = src_row_reg & rmask;
        col_half  = col >> 1;
        w1        = (wl_eff == '0);
        h1        = (hl_eff == '0);
        last_col  = (col == wmask);
        last_row  = (row == rmask);
        first_col = (col_half == '0);
        first_row = ((row >> 1) == '0);
        pair_done = w1 || col[0];
        hsum      = mlbd_pkg::pair_sum(w1 ? s_tdata : pair_hold_reg, s_tdata);
        wr_need   = pair_done && !h1 && !row[0];
        rd_need   = pair_done && !h1 && row[0];
        emit      = pair_done && (h1 || row[0]);
    end

    always_comb begin
        if (last_col) begin
            src_col_next = '0;
            src_row_next = last_row ? '0 : row + 1'b1;
        end else begin
            src_col_next = col + 1'b1;
            src_row_next = row;
        end
    end

    assign s_tready = !s1_valid_reg || s1_take;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            src_col_reg <= '0;
            src_row_reg <= '0;
        end else if (s_acc) begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
        end
    end

    // even-column pixel waits for its partner
    always_ff @(posedge aclk) begin
        if (s_acc && !pair_done) begin
            pair_hold_reg <= s_tdata;
        end
    end

    always_comb begin
        s1_next.hsum       = hsum;
        s1_next.use_above  = !h1;
        s1_next.alpha_zero = !has_alpha_reg
                             || (border_tb_reg && (first_row || last_row))
                             || (border_lr_reg && (first_col || last_col));
        s1_next.level_end  = last_col && last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= emit;
        end else if (s1_take) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && emit) begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    // even rows store pair sums, odd rows read them back as the matching pair completes
    assign ram_wr_en   = s_acc && wr_need;
    assign ram_wr_addr = col_half[ADDR_W-1:0];
    assign ram_wr_data = hsum;
    assign ram_rd_en   = s_acc && rd_need;
    assign ram_rd_addr = col_half[ADDR_W-1:0];

endmodule

>>> src/mlbd_back.sv
// vertical sum, channel averaging, alpha masking and the output register
// depends on mlbd_pkg
module mlbd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s1_valid,
    input  mlbd_pkg::mlbd_stage_t        s1,
    input  logic [mlbd_pkg::SUM_W-1:0]   ram_rd_data,
    output logic                         s1_take,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mlbd_pkg::PIX_W-1:0]   m_tdata,
    output logic                         m_tlast
);

    localparam int LANE_W = mlbd_pkg::LANE_W;

    logic                       m_valid_reg;
    logic [mlbd_pkg::PIX_W-1:0] m_data_reg, m_data_next;
    logic                       m_last_reg;
    logic [LANE_W:0]            lane_sum;

    always_comb begin
        m_data_next = '0;
        for (int c = 0; c < 4; c++) begin
            if (s1.use_above) begin
                lane_sum = {1'b0, ram_rd_data[c*LANE_W +: LANE_W]}
                         + {1'b0, s1.hsum[c*LANE_W +: LANE_W]};
            end else begin
                // single source row counts twice
                lane_sum = {s1.hsum[c*LANE_W +: LANE_W], 1'b0};
            end
            m_data_next[c*8 +: 8] = lane_sum[LANE_W:2];
        end
        if (s1.alpha_zero) begin
            m_data_next[31:24] = 8'd0;
        end
    end

    assign s1_take = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_take) begin
            m_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_take && s1_valid) begin
            m_data_reg <= m_data_next;
            m_last_reg <= s1.level_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> src/mip_level_box_downsampler_top.sv
// pipeline: two register stages, s1 and the output register; an emitting source pixel
//   passes through both before m_tvalid rises for its output transaction
// throughput: one source pixel per cycle absent output backpressure; a line store entry is
//   written on an even row, read on the odd row below, never both at once, so no access stalls the input
// reset (aresetn low, synchronous) clears the pipeline valids and the position and returns
//   the config to its defaults; the line store needs no clearing, an odd row only reads
//   what the row above wrote
// top level of the mip level box downsampler; depends on mlbd_pkg, mlbd_front,
// mlbd_back, mlbd_ram and the assertion macro header
`include "mip_level_box_downsampler_top_assert.svh"

module mip_level_box_downsampler_top #(
    parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port, no read-back
    input  logic                            cfg_wr_en,
    input  logic [mlbd_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [mlbd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // source pixel stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mlbd_pkg::PIX_W-1:0]      s_tdata,   // [31:0] pixel
    // next-level pixel stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mlbd_pkg::PIX_W-1:0]      m_tdata,   // [31:0] mip_pixel
    output logic                            m_tlast    // level_end
);

    localparam int ADDR_W = mlbd_pkg::addr_bits(MAX_WIDTH);
    localparam int DEPTH  = 1 << ADDR_W;

    // stage between the line store access and the averaging
    logic                       s1_valid, s1_take;
    mlbd_pkg::mlbd_stage_t      s1;

    // line store of horizontal pair sums
    logic                       ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]          ram_wr_addr, ram_rd_addr;
    logic [mlbd_pkg::SUM_W-1:0] ram_wr_data, ram_rd_data;

    mlbd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s1_take      (s1_take),
        .s1_valid     (s1_valid),
        .s1           (s1),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr)
    );

    mlbd_ram #(
        .WIDTH (mlbd_pkg::SUM_W),
        .DEPTH (DEPTH)
    ) u_row_sums (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mlbd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1_valid    (s1_valid),
        .s1          (s1),
        .ram_rd_data (ram_rd_data),
        .s1_take     (s1_take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // a pixel row either stores or reads the line store, never both at once
    `MLBD_ASSERT_SAME(a_no_rw_collide, ram_wr_en, !ram_rd_en, "line store read and write collide")
    // every line store read feeds an item in the averaging stage next cycle
    `MLBD_ASSERT_NEXT(a_read_feeds_stage, ram_rd_en, s1_valid, "line store read without stage item")
    // input stalls only when both the stage and the output register are full and blocked
    `MLBD_ASSERT_SAME(a_stall_cause, !s_tready, s1_valid && m_tvalid && !m_tready,
                      "input stalled without downstream backpressure")

endmodule
